// ----- rtl/core/nvmwl_pkg.sv -----
// Shared types and constants for the NVM wear and latency monitor.
`default_nettype none
package nvmwl_pkg;
  localparam logic [2:0] FUNC_READ   = 3'd0;
  localparam logic [2:0] FUNC_WRITE  = 3'd1;
  localparam logic [2:0] FUNC_ATOMIC = 3'd2;
  localparam logic [2:0] FUNC_TICK   = 3'd3;
  localparam logic [2:0] FUNC_PROBER = 3'd4;
  localparam logic [2:0] FUNC_PROBEW = 3'd5;
  localparam logic [2:0] FUNC_CLEAR  = 3'd6;

  localparam logic [1:0] REG_READ_CYCLES  = 2'd0;
  localparam logic [1:0] REG_WRITE_CYCLES = 2'd1;
  localparam logic [1:0] REG_BANK_COUNT   = 2'd2;
  localparam logic [1:0] REG_ENDURANCE    = 2'd3;

  localparam int CNT_W  = 50;
  localparam int PAGE_W = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};
  localparam logic [CNT_W-1:0] CHECK_PERIOD = 50'd100000;
  localparam logic [16:0] CHECK_LAST = 17'd99999;  // wrap point of total mod period
  localparam int SAMPLE_STEP = 1000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture input word, do fast updates
    logic div_step;   // one restoring-division step (frame / banks)
    logic page_rd;    // issue page counter read
    logic page_wr;    // write page counter back, set hot
    logic scan_step;  // visit one bank counter
    logic finish;     // form result word
  } nvmwl_cmd_t;

  typedef struct packed {
    logic is_write;
  } nvmwl_stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/nvmwl_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module nvmwl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/nvmwl_ctrl.sv -----
// Sequencer for the monitor: steps division, page update and bank scan.
`default_nettype none
module nvmwl_ctrl #(
  parameter int DIV_STEPS  = 52,
  parameter int SCAN_STEPS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_fire,
  input  wire logic                   out_free,
  input  wire nvmwl_pkg::nvmwl_stat_t stat,
  output nvmwl_pkg::nvmwl_cmd_t       cmd,
  output logic                        busy,
  output logic                        out_load
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PRD  = 3'd2;
  localparam logic [2:0] S_PWR  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam int CW = $clog2(DIV_STEPS + SCAN_STEPS + 1);

  logic [2:0] state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.is_write) begin
          state_next = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next = cnt + 1'b1;
          if (cnt == CW'(DIV_STEPS - 1)) begin
            cnt_next = '0;
            state_next = S_PRD;
          end
        end
      end
      S_PRD: begin
        cmd.page_rd = 1'b1;
        state_next = S_PWR;
      end
      S_PWR: begin
        cmd.page_wr = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(SCAN_STEPS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/nvmwl_dp.sv -----
// Datapath: queue count, write counters, bank division, page RAM, bank scan.
`default_nettype none
module nvmwl_dp #(
  parameter int MAX_BANKS     = 8,
  parameter int TRACKED_PAGES = 1024,
  parameter int QUEUE_LIMIT   = 32,
  parameter int ADDR_WIDTH    = 32,
  parameter int FRAME_W       = 52,
  parameter int BANK_IW       = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire nvmwl_pkg::nvmwl_cmd_t  cmd,
  output nvmwl_pkg::nvmwl_stat_t      stat,
  input  wire logic [2:0]             func,
  input  wire logic [ADDR_WIDTH-1:0]  address,
  input  wire logic [15:0]            read_cycles,
  input  wire logic [15:0]            write_cycles_cfg,
  input  wire logic [3:0]             bank_count,
  input  wire logic [49:0]            endurance_limit,
  output logic [17:0]                 r_latency,
  output logic                        r_accepted,
  output logic                        r_endx,
  output logic                        r_hot,
  output logic                        r_imb,
  output logic [7:0]                  r_depth
);
  localparam int PW = $clog2(TRACKED_PAGES);
  localparam int BW = 7;  // banks up to 127
  localparam int PAGE_W_L = nvmwl_pkg::PAGE_W;

  logic [7:0] pending;
  logic [49:0] total;
  logic [16:0] wmod;          // total mod the check period
  logic [49:0] bank_cnt [MAX_BANKS];
  logic [2:0] f;
  logic [17:0] lat;
  logic acc;
  logic [FRAME_W-1:0] quo;    // dividend shifts out, quotient shifts in
  logic [BW-1:0] rem;
  logic [BW-1:0] banks;
  logic [FRAME_W-1:0] page;
  logic hot, endx;
  logic [PAGE_W_L-1:0] ram_q;
  logic [BANK_IW-1:0] scan_idx;
  logic [49:0] mx, mn;
  logic any, chk;
  logic [BW:0] trial;
  logic [FRAME_W-1:0] est;
  logic [FRAME_W+10:0] est_p;
  logic [FRAME_W-1:0] slot_r;
  logic [FRAME_W+9:0] back;
  logic [FRAME_W-1:0] diff;
  logic trk;
  logic [PAGE_W_L-1:0] ram_d;
  logic [PAGE_W_L+9:0] hot_prod;
  logic ram_we;
  logic [PW-1:0] raddr;
  logic [PW:0] clr;
  logic clearing;
  logic [51:0] mn3;

  // effective bank count, clamped
  always_comb begin
    if (bank_count == 4'd0) banks = BW'(1);
    else if (BW'(bank_count) > BW'(MAX_BANKS)) banks = BW'(MAX_BANKS);
    else banks = BW'(bank_count);
  end

  // restoring division step
  assign trial = {rem, quo[FRAME_W-1]} - {1'b0, banks};

  assign stat.is_write = (f == nvmwl_pkg::FUNC_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      total <= '0;
      wmod <= '0;
      for (int i = 0; i < MAX_BANKS; i++) bank_cnt[i] <= '0;
    end else begin
      if (cmd.load) begin
        f <= func;
        lat <= '0;
        acc <= 1'b0;
        endx <= 1'b0;
        quo <= FRAME_W'(address >> 12);
        rem <= '0;
        case (func)
          nvmwl_pkg::FUNC_READ: begin
            lat <= 18'(read_cycles) + 18'(pending);
            if (pending != 8'hFF) pending <= pending + 1'b1;
          end
          nvmwl_pkg::FUNC_WRITE: begin
            lat <= 18'(write_cycles_cfg) + 18'(pending);
            if (pending != 8'hFF) pending <= pending + 1'b1;
            if (total != nvmwl_pkg::CNT_MAX) begin
              total <= total + 1'b1;
              wmod <= (wmod == nvmwl_pkg::CHECK_LAST) ? '0 : wmod + 1'b1;
            end
          end
          nvmwl_pkg::FUNC_ATOMIC: begin
            lat <= 18'(read_cycles) + 18'(write_cycles_cfg) + 18'(pending);
            if (pending != 8'hFF) pending <= pending + 1'b1;
            if (total != nvmwl_pkg::CNT_MAX) begin
              total <= total + 1'b1;
              wmod <= (wmod == nvmwl_pkg::CHECK_LAST) ? '0 : wmod + 1'b1;
            end
          end
          nvmwl_pkg::FUNC_TICK: begin
            if (pending != 8'd0) pending <= pending - 1'b1;
          end
          nvmwl_pkg::FUNC_PROBER: acc <= (pending < 8'(QUEUE_LIMIT));
          nvmwl_pkg::FUNC_PROBEW:
            acc <= (pending < 8'(QUEUE_LIMIT)) && (total < endurance_limit);
          nvmwl_pkg::FUNC_CLEAR: begin
            total <= '0;
            wmod <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.div_step) begin
        // frame / banks, one quotient bit per step
        if (!trial[BW]) begin
          rem <= trial[BW-1:0];
          quo <= {quo[FRAME_W-2:0], 1'b1};
        end else begin
          rem <= {rem[BW-2:0], quo[FRAME_W-1]};
          quo <= {quo[FRAME_W-2:0], 1'b0};
        end
      end
      if (cmd.page_rd) begin
        // bank update uses the final remainder
        if (bank_cnt[rem[BANK_IW-1:0]] != nvmwl_pkg::CNT_MAX)
          bank_cnt[rem[BANK_IW-1:0]] <= bank_cnt[rem[BANK_IW-1:0]] + 1'b1;
        endx <= (total > endurance_limit);
      end
    end
  end

  // page / 1000 estimate by reciprocal multiply; exact for every multiple of
  // 1000 in the tracked range, and a miss elsewhere fails the back-check
  assign page = quo;
  always_comb begin
    est_p = (FRAME_W+11)'(page) * (FRAME_W+11)'(1049);  // 1049 / 2^20 just above 1/1000
    est = FRAME_W'(est_p >> 20);
  end
  assign back = (FRAME_W+10)'(slot_r) * (FRAME_W+10)'(nvmwl_pkg::SAMPLE_STEP);
  assign diff = page - FRAME_W'(back);

  always_ff @(posedge clk) begin
    if (cmd.page_rd) slot_r <= est;
  end
  always_comb begin
    trk = 1'b0;
    if (diff == '0 && slot_r < FRAME_W'(TRACKED_PAGES)) trk = 1'b1;
  end

  // page counter RAM
  assign ram_we = cmd.page_wr && trk && (f == nvmwl_pkg::FUNC_WRITE);
  assign ram_d = (ram_q == nvmwl_pkg::PAGE_MAX) ? ram_q : ram_q + 1'b1;
  assign raddr = cmd.page_wr ? slot_r[PW-1:0] : est[PW-1:0];

  // count > limit / 1000  <=>  1000 * count > limit
  assign hot_prod = {ram_d, 10'b0} - (PAGE_W_L+10)'({ram_d, 4'b0})
                    - (PAGE_W_L+10)'({ram_d, 3'b0});

  // clearing pass after reset
  assign clearing = !clr[PW];
  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (clearing) clr <= clr + 1'b1;
  end

  nvmwl_ram #(.WIDTH(PAGE_W_L), .DEPTH(TRACKED_PAGES)) u_pages (
    .clk(clk),
    .we(ram_we || clearing),
    .addr(clearing ? clr[PW-1:0] : raddr),
    .wdata(clearing ? '0 : ram_d),
    .rdata(ram_q)
  );

  // hot flag and bank scan for imbalance
  always_ff @(posedge clk) begin
    if (cmd.page_wr) begin
      hot <= trk && (hot_prod > (PAGE_W_L+10)'(endurance_limit));
      scan_idx <= '0;
      any <= 1'b0;
      mx <= '0;
      mn <= '0;
      chk <= (total != '0) && (wmod == '0);
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (bank_cnt[scan_idx] != '0) begin
        any <= 1'b1;
        if (!any || bank_cnt[scan_idx] > mx) mx <= bank_cnt[scan_idx];
        if (!any || bank_cnt[scan_idx] < mn) mn <= bank_cnt[scan_idx];
      end
    end
  end

  // max/min > 2  <=>  max >= 3*min
  assign mn3 = 52'(mn) + 52'({mn, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      r_latency <= lat;
      r_accepted <= acc;
      r_endx <= endx && (f == nvmwl_pkg::FUNC_WRITE);
      r_hot <= hot && (f == nvmwl_pkg::FUNC_WRITE);
      r_imb <= (f == nvmwl_pkg::FUNC_WRITE) && chk && any && (52'(mx) >= mn3);
      r_depth <= pending;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/nvm_wear_and_latency_monitor_core.sv -----
// Top level of the NVM wear and latency monitor.
// Usage:
//   s_axis carries one input word per access: func and address. Each word
//   yields one result word on m_axis with latency, probe answer, endurance,
//   hot-page and bank-imbalance flags and the queue depth after the word.
//   The APB port sets read/write latency, bank count and endurance limit.
// Sequence:
//   Non-write words skip the division steps and go to the result. A write
//   runs a bit-serial frame/bank division, a page-counter RAM read and
//   write and a scan of the 8 bank counters. One word is in flight at a
//   time; the next word is taken the cycle after the result is loaded.
// Reset:
//   Synchronous rst clears the queue and all counters and restores the
//   register defaults. A clearing pass then zeroes the page counter RAM;
//   s_axis_tready stays low during it.
// Stall:
//   The result waits in the output register while m_axis_tready is low;
//   the next word can be taken into work while it waits.
`default_nettype none
module nvm_wear_and_latency_monitor_core #(
  parameter int MAX_BANKS     = 8,
  parameter int TRACKED_PAGES = 1024,
  parameter int QUEUE_LIMIT   = 32,
  parameter int ADDR_WIDTH    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [((ADDR_WIDTH + 10) / 8) * 8 - 1:0] s_axis_tdata,
                                           // [2:0] func, [ADDR_WIDTH+2:3] address, zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [17:0] latency, [18] accepted,
                                           // [19] endurance_exceeded, [20] hot_page,
                                           // [21] bank_imbalance, [29:22] queue_depth
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  localparam int FRAME_W = ADDR_WIDTH - 12;
  localparam int BANK_IW = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int PW = $clog2(TRACKED_PAGES);

  logic [15:0] read_cycles, write_cycles_cfg;
  logic [3:0] bank_count;
  logic [49:0] endurance_limit;
  logic [1:0] ridx;
  logic [PW:0] clr_cnt;

  assign pready = 1'b1;
  assign ridx = paddr[4:3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_cycles <= 16'd10;
      write_cycles_cfg <= 16'd50;
      bank_count <= 4'd8;
      endurance_limit <= 50'd1000000000000000;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        nvmwl_pkg::REG_READ_CYCLES:  read_cycles <= pwdata[15:0];
        nvmwl_pkg::REG_WRITE_CYCLES: write_cycles_cfg <= pwdata[15:0];
        nvmwl_pkg::REG_BANK_COUNT:   bank_count <= pwdata[3:0];
        nvmwl_pkg::REG_ENDURANCE:    endurance_limit <= pwdata[49:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      nvmwl_pkg::REG_READ_CYCLES:  prdata = 64'(read_cycles);
      nvmwl_pkg::REG_WRITE_CYCLES: prdata = 64'(write_cycles_cfg);
      nvmwl_pkg::REG_BANK_COUNT:   prdata = 64'(bank_count);
      default:                     prdata = 64'(endurance_limit);
    endcase
  end

  // match the datapath clearing pass
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (!clr_cnt[PW]) clr_cnt <= clr_cnt + 1'b1;
  end

  nvmwl_pkg::nvmwl_cmd_t cmd;
  nvmwl_pkg::nvmwl_stat_t stat;
  logic busy, out_load, in_fire;
  logic [17:0] r_latency;
  logic r_acc, r_endx, r_hot, r_imb;
  logic [7:0] r_depth;

  assign s_axis_tready = !busy && clr_cnt[PW];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  nvmwl_ctrl #(.DIV_STEPS(FRAME_W), .SCAN_STEPS(MAX_BANKS)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .stat(stat), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  nvmwl_dp #(
    .MAX_BANKS(MAX_BANKS), .TRACKED_PAGES(TRACKED_PAGES),
    .QUEUE_LIMIT(QUEUE_LIMIT), .ADDR_WIDTH(ADDR_WIDTH),
    .FRAME_W(FRAME_W), .BANK_IW(BANK_IW)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .func(s_axis_tdata[2:0]), .address(s_axis_tdata[ADDR_WIDTH+2:3]),
    .read_cycles(read_cycles), .write_cycles_cfg(write_cycles_cfg),
    .bank_count(bank_count), .endurance_limit(endurance_limit),
    .r_latency(r_latency), .r_accepted(r_acc), .r_endx(r_endx),
    .r_hot(r_hot), .r_imb(r_imb), .r_depth(r_depth)
  );

  // output word register
  logic load_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      load_d <= 1'b0;
    end else begin
      load_d <= out_load;
      if (load_d) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end
  assign m_axis_tdata = {2'b00, r_depth, r_imb, r_hot, r_endx, r_acc, r_latency};
endmodule
`default_nettype wire

// ----- tb/nvm_wear_and_latency_monitor_core_tb.sv -----
// Testbench for the NVM wear and latency monitor core, checked against a predictor.
`default_nettype none
module nvm_wear_and_latency_monitor_core_tb;

  localparam int NBANK      = 8;
  localparam int NPAGE      = 1024;
  localparam int QLIMIT     = 32;
  localparam int WDOG_LIMIT = 6000;
  localparam int SETTLE     = 80;

  // Result word layout, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0]  depth;
    logic        imb;
    logic        hot;
    logic        endx;
    logic        acc;
    logic [17:0] lat;
  } mon_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // [2:0] func, [34:3] address, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [17:0] latency, [18] accepted, [19] endurance_exceeded,
                                   // [20] hot_page, [21] bank_imbalance, [29:22] queue_depth
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  nvm_wear_and_latency_monitor_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of registers and state
  logic [15:0]      cfg_rd_cycles;
  logic [15:0]      cfg_wr_cycles;
  logic [3:0]       cfg_banks;
  logic [nvmwl_pkg::CNT_W-1:0] cfg_endurance;
  logic [7:0]       pend_cnt;
  logic [nvmwl_pkg::CNT_W-1:0] write_total;
  logic [nvmwl_pkg::CNT_W-1:0] bank_wear [NBANK];
  logic [nvmwl_pkg::PAGE_W-1:0] page_wear [NPAGE];

  mon_result_t expected_words[$];
  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int words_in  = 0;
  int words_out = 0;
  int hot_seen  = 0;
  int endx_seen = 0;
  int sat_seen  = 0;
  int wdog      = 0;

  function automatic int eff_banks();
    if (cfg_banks == 0) return 1;
    if (cfg_banks > NBANK) return NBANK;
    return cfg_banks;
  endfunction

  function automatic logic wear_skewed();
    logic [nvmwl_pkg::CNT_W-1:0] mx, mn;
    logic any;
    mx = '0; mn = '0; any = 1'b0;
    for (int i = 0; i < NBANK; i++) begin
      if (bank_wear[i] != 0) begin
        if (!any || bank_wear[i] > mx) mx = bank_wear[i];
        if (!any || bank_wear[i] < mn) mn = bank_wear[i];
        any = 1'b1;
      end
    end
    if (!any) return 1'b0;
    return (mx / mn) > 2;
  endfunction

  // Apply one input word to the predictor state and return its result
  function automatic mon_result_t predict_word(logic [2:0] fn, logic [31:0] addr);
    mon_result_t r;
    logic [19:0] frame;
    int b, bank, page, slot;
    logic [7:0] pend0;
    r = '0;
    b = eff_banks();
    pend0 = pend_cnt;
    case (fn)
      nvmwl_pkg::FUNC_READ: begin
        r.lat = cfg_rd_cycles + pend0;
        if (pend_cnt != 8'hff) pend_cnt++;
      end
      nvmwl_pkg::FUNC_WRITE: begin
        frame = addr[31:12];
        bank = frame % b;
        page = frame / b;
        r.lat = cfg_wr_cycles + pend0;
        if (pend_cnt != 8'hff) pend_cnt++;
        if (write_total != nvmwl_pkg::CNT_MAX) write_total++;
        if (bank_wear[bank] != nvmwl_pkg::CNT_MAX) bank_wear[bank]++;
        if (page % nvmwl_pkg::SAMPLE_STEP == 0) begin
          slot = page / nvmwl_pkg::SAMPLE_STEP;
          if (slot < NPAGE) begin
            if (page_wear[slot] != nvmwl_pkg::PAGE_MAX) page_wear[slot]++;
            r.hot = page_wear[slot] > (cfg_endurance / nvmwl_pkg::SAMPLE_STEP);
          end
        end
        if (write_total != 0 && write_total % nvmwl_pkg::CHECK_PERIOD == 0)
          r.imb = wear_skewed();
        r.endx = write_total > cfg_endurance;
      end
      nvmwl_pkg::FUNC_ATOMIC: begin
        r.lat = cfg_rd_cycles + cfg_wr_cycles + pend0;
        if (pend_cnt != 8'hff) pend_cnt++;
        if (write_total != nvmwl_pkg::CNT_MAX) write_total++;
      end
      nvmwl_pkg::FUNC_TICK:   if (pend_cnt != 0) pend_cnt--;
      nvmwl_pkg::FUNC_PROBER: r.acc = pend_cnt < QLIMIT;
      nvmwl_pkg::FUNC_PROBEW: r.acc = (pend_cnt < QLIMIT) && (write_total < cfg_endurance);
      nvmwl_pkg::FUNC_CLEAR:  write_total = '0;
      default: ;
    endcase
    r.depth = pend_cnt;
    return r;
  endfunction

  // Send one word; called and returning at a falling edge with tvalid left high
  task automatic send_word(logic [2:0] fn, logic [31:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, addr, fn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_words.push_back(predict_word(fn, addr));
    words_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // Register write, only while nothing is in flight
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    drain();
    repeat (SETTLE) @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      nvmwl_pkg::REG_READ_CYCLES:  cfg_rd_cycles = val[15:0];
      nvmwl_pkg::REG_WRITE_CYCLES: cfg_wr_cycles = val[15:0];
      nvmwl_pkg::REG_BANK_COUNT:   cfg_banks     = val[3:0];
      default:                     cfg_endurance = val[nvmwl_pkg::CNT_W-1:0];
    endcase
  endtask

  task automatic set_config(int rd, int wr, int banks,
                            logic [nvmwl_pkg::CNT_W-1:0] endur);
    write_reg(nvmwl_pkg::REG_READ_CYCLES, 64'(rd));
    write_reg(nvmwl_pkg::REG_WRITE_CYCLES, 64'(wr));
    write_reg(nvmwl_pkg::REG_BANK_COUNT, 64'(banks));
    write_reg(nvmwl_pkg::REG_ENDURANCE, 64'(endur));
  endtask

  // Address landing on a sampled page, mostly on a few low slots so pages get hot
  function automatic logic [31:0] tracked_addr();
    int b, maxslot, slot, bank;
    logic [19:0] frame;
    b = eff_banks();
    maxslot = ((1048575 - (b - 1)) / b) / nvmwl_pkg::SAMPLE_STEP;
    slot = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(maxslot);
    bank = $urandom_range(b - 1);
    frame = 20'(slot * nvmwl_pkg::SAMPLE_STEP * b + bank);
    return {frame, 12'($urandom)};
  endfunction

  task automatic random_words(int n, int tick_w, logic pause_mid);
    int k;
    logic [2:0] fn;
    logic [31:0] addr;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      k = $urandom_range(99);
      addr = $urandom;
      if (k < 40) begin
        fn = nvmwl_pkg::FUNC_WRITE;
        if (k < 30) addr = tracked_addr();
      end else if (k < 52)            fn = nvmwl_pkg::FUNC_READ;
      else if (k < 58)                fn = nvmwl_pkg::FUNC_ATOMIC;
      else if (k < 58 + tick_w)       fn = nvmwl_pkg::FUNC_TICK;
      else if (k < 66 + tick_w)       fn = nvmwl_pkg::FUNC_PROBER;
      else if (k < 74 + tick_w)       fn = nvmwl_pkg::FUNC_PROBEW;
      else if (k < 76 + tick_w)       fn = nvmwl_pkg::FUNC_CLEAR;
      else if (k < 78 + tick_w)       fn = 3'd7;
      else                            fn = nvmwl_pkg::FUNC_WRITE;
      send_word(fn, addr);
    end
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    mon_result_t got, exp_w;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time,
                 expected_words.size());
        $display("FAILURE");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[29:0];
        words_out++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
        end else begin
          exp_w = expected_words.pop_front();
          if (got.hot) hot_seen++;
          if (got.endx) endx_seen++;
          if (got.depth == 8'hff) sat_seen++;
          if (got !== exp_w || m_axis_tdata[31:30] !== 2'b00) begin
            errors++;
            $display("%0t: mismatch exp lat=%0d acc=%b endx=%b hot=%b imb=%b depth=%0d",
                     $time, exp_w.lat, exp_w.acc, exp_w.endx, exp_w.hot, exp_w.imb,
                     exp_w.depth);
            $display("%0t:          act lat=%0d acc=%b endx=%b hot=%b imb=%b depth=%0d",
                     $time, got.lat, got.acc, got.endx, got.hot, got.imb, got.depth);
          end
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  task automatic test_directed();
    send_word(nvmwl_pkg::FUNC_TICK, 32'h0);          // tick on empty queue
    send_word(nvmwl_pkg::FUNC_READ, 32'h0);
    send_word(nvmwl_pkg::FUNC_READ, 32'hffff_ffff);
    send_word(nvmwl_pkg::FUNC_WRITE, 32'h0);         // page zero is sampled
    send_word(nvmwl_pkg::FUNC_WRITE, 32'hffff_ffff);
    send_word(nvmwl_pkg::FUNC_WRITE, 32'h01f4_0000); // frame 8000: page 1000, slot 1
    send_word(nvmwl_pkg::FUNC_ATOMIC, 32'h1234_5678);
    send_word(nvmwl_pkg::FUNC_PROBER, 32'h0);
    send_word(nvmwl_pkg::FUNC_PROBEW, 32'h0);
    send_word(nvmwl_pkg::FUNC_CLEAR, 32'h0);
    send_word(3'd7, 32'haaaa_5555);                  // unused code
    send_word(nvmwl_pkg::FUNC_TICK, 32'h0);
    send_word(nvmwl_pkg::FUNC_PROBEW, 32'h0);
    for (int i = 0; i < 34; i++)
      send_word(nvmwl_pkg::FUNC_READ, 32'h5555_aaaa); // past queue limit
    send_word(nvmwl_pkg::FUNC_PROBER, 32'h0);
    send_word(nvmwl_pkg::FUNC_PROBEW, 32'h0);
    for (int i = 0; i < 40; i++) send_word(nvmwl_pkg::FUNC_TICK, 32'h0);
  endtask

  task automatic test_extremes();
    // one bank, zero latency, endurance of one: hot at once, over-limit from the second write
    set_config(0, 0, 1, 50'd1);
    send_word(nvmwl_pkg::FUNC_WRITE, 32'h0);
    send_word(nvmwl_pkg::FUNC_WRITE, 32'h0);
    send_word(nvmwl_pkg::FUNC_PROBEW, 32'h0);
    send_word(nvmwl_pkg::FUNC_WRITE, 32'hfa00_0000); // slot 1024, beyond the tracked range
    send_word(nvmwl_pkg::FUNC_WRITE, 32'hffff_f000);
    send_word(nvmwl_pkg::FUNC_ATOMIC, 32'h0);
    send_word(nvmwl_pkg::FUNC_CLEAR, 32'h0);
    send_word(nvmwl_pkg::FUNC_PROBEW, 32'h0);
    random_words(150, 12, 1'b0);
    // widest latencies, bank count zero and above the maximum
    set_config(65535, 65535, 0, nvmwl_pkg::CNT_MAX);
    random_words(100, 12, 1'b0);
    write_reg(nvmwl_pkg::REG_BANK_COUNT, 64'd15);
    random_words(100, 12, 1'b0);
  endtask

  task automatic test_idle_phases();
    set_config(7, 300, 3, 50'd5000);
    idle_pct = 57; stall_pct = 0;
    random_words(280, 12, 1'b1);
    set_config(123, 45, 5, 50'd20000);
    idle_pct = 0; stall_pct = 57;
    random_words(280, 12, 1'b0);
    set_config(1, 2, 8, 50'd3000);
    idle_pct = 27; stall_pct = 27;
    random_words(280, 12, 1'b0);
    idle_pct = 0; stall_pct = 0;
  endtask

  task automatic test_queue_saturation();
    // few ticks so the pending count runs up to its ceiling
    set_config(65535, 65535, 2, 50'd1000);
    idle_pct = 27; stall_pct = 27;
    random_words(300, 1, 1'b0);
    idle_pct = 0; stall_pct = 0;
    for (int i = 0; i < 40; i++) send_word(nvmwl_pkg::FUNC_TICK, 32'h0);
    random_words(50, 12, 1'b0);
  endtask

  initial begin
    cfg_rd_cycles = 16'd10;
    cfg_wr_cycles = 16'd50;
    cfg_banks     = 4'd8;
    cfg_endurance = 50'd1000000000000000;
    pend_cnt      = '0;
    write_total   = '0;
    for (int i = 0; i < NBANK; i++) bank_wear[i] = '0;
    for (int i = 0; i < NPAGE; i++) page_wear[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_extremes();
    test_idle_phases();
    test_queue_saturation();
    drain();
    repeat (SETTLE) @(negedge clk);
    $display("Sent %0d words, checked %0d results over 8 register settings and 4 idle modes.",
             words_in, words_out);
    $display("Hot-page flags %0d, over-endurance flags %0d, saturated queue %0d, errors %0d.",
             hot_seen, endx_seen, sat_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- nvm_wear_and_latency_monitor_core.f -----
rtl/core/nvmwl_pkg.sv
rtl/core/nvmwl_ram.sv
rtl/core/nvmwl_ctrl.sv
rtl/core/nvmwl_dp.sv
rtl/core/nvm_wear_and_latency_monitor_core.sv
tb/nvm_wear_and_latency_monitor_core_tb.sv
